// ===== design/ircfr_pkg.sv =====
// Shared types, codes and helpers for the infrared command frame receiver.
// No dependencies; imported by every module of the block.
package ircfr_pkg;

   localparam int STORE_DEPTH = 4;
   localparam int OPQ_DEPTH   = 2;
   localparam int RSPQ_DEPTH  = 2;

   localparam logic [0:0] KIND_FRAME = 1'b0;
   localparam logic [0:0] KIND_DONE  = 1'b1;

   localparam logic CSR_OWN_ADDRESS = 1'b0;   // word index of the own_address register
   localparam logic [3:0] OWN_ADDRESS_RESET = 4'd1;

   typedef enum logic [1:0] {
      PH_READY     = 2'd0,
      PH_RECEIVING = 2'd1,
      PH_COMPLETED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [0:0]  kind;
      logic [15:0] frame_word;
   } req_type;

   typedef struct packed {
      logic [3:0]  command_type;
      logic [3:0]  direction;
      logic [7:0]  arg_byte;
      logic [15:0] arg_word;
      logic [2:0]  byte_count;
      logic        overrun;
   } rsp_type;

   // Classified beat handed from front to back
   typedef struct packed {
      logic       is_done;
      logic [7:0] data;
   } op_type;

   // Bytes carried by each command type
   function automatic logic [2:0] length_of_type(input logic [3:0] t);
      logic [2:0] len;
      case (t) inside
         4'd1, 4'd2, 4'd5: len = 3'd4;
         4'd3, 4'd4:       len = 3'd1;
         default:          len = 3'd3;
      endcase
      return len;
   endfunction

   // Frame bits 6..11 -> data 0..5, frame bits 4..5 -> data 6..7
   function automatic logic [7:0] remap_frame(input logic [15:0] w);
      return {w[5:4], w[11:6]};
   endfunction

endpackage

// ===== design/ir_command_frame_receiver.sv =====
// Infrared command frame receiver, top level: CSR port, front and back ends.
// Throughput: one beat per cycle while the op queue is not full; the back end
// retires one op a cycle while the two-entry result queue has room. The last op
// of a command passes the op queue, then the result queue, which drives rsp_item.
// Reset (synchronous): queues empty, phase ready, store zero, own_address 1.
// Depends on ircfr_pkg, ircfr_front and ircfr_back.
module ir_command_frame_receiver import ircfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_item,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [3:0] own_address_ff, own_address_in;
   logic       csr_write;
   logic       op_valid, op_take;
   op_type     op_item;

   // Register access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      own_address_in = own_address_ff;
      if (csr_write && (paddr[2] == CSR_OWN_ADDRESS)) begin
         own_address_in = pwdata[3:0];
      end
   end

   assign prdata = (paddr[2] == CSR_OWN_ADDRESS) ? {28'd0, own_address_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDRESS_RESET;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   ircfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_address_ff),
      .push        (push),
      .full        (full),
      .req_item    (req_item),
      .op_valid    (op_valid),
      .op_take     (op_take),
      .op_item     (op_item)
   );

   ircfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op_item  (op_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== design/ircfr_front.sv =====
// Front end: accepts request beats, drops foreign frames, remaps the data byte
// and queues classified ops for the back end. Depends on ircfr_pkg.
module ircfr_front import ircfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [3:0] own_address,
   input  logic       push,
   output logic       full,
   input  req_type    req_item,
   output logic       op_valid,
   input  logic       op_take,
   output op_type     op_item
);

   localparam int PW = $clog2(OPQ_DEPTH);
   localparam int CW = $clog2(OPQ_DEPTH + 1);

   op_type          queue_ff [OPQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            accept, keep, deq;
   op_type          op_new;

   // Classify: done beats always pass, frames only with a matching address
   assign accept = push && !full;
   assign keep   = (req_item.kind == KIND_DONE) || (req_item.frame_word[3:0] == own_address);
   assign op_new.is_done = (req_item.kind == KIND_DONE);
   assign op_new.data    = remap_frame(req_item.frame_word);

   assign full     = (count_ff == CW'(OPQ_DEPTH));
   assign op_valid = (count_ff != '0);
   assign op_item  = queue_ff[rd_ptr_ff];
   assign deq      = op_valid && op_take;

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = (wr_ptr_ff == PW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((accept && keep) && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!(accept && keep) && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

// ===== design/ircfr_back.sv =====
// Back end: command assembly state machine, 4-byte command store and the
// result queue. Depends on ircfr_pkg.
module ircfr_back import ircfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   output logic    op_take,
   input  op_type  op_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   localparam int PW = $clog2(RSPQ_DEPTH);
   localparam int CW = $clog2(RSPQ_DEPTH + 1);

   phase_type       phase_ff, phase_in;
   logic [1:0]      bytes_left_ff, bytes_left_in;
   logic [1:0]      write_index_ff, write_index_in;
   logic [7:0]      store_ff [STORE_DEPTH];
   logic [7:0]      store_in [STORE_DEPTH];
   logic [2:0]      first_len;
   logic            emit, emit_ovr;
   rsp_type         rsp_new;

   rsp_type         rq_ff [RSPQ_DEPTH];
   logic [PW-1:0]   rq_wr_ff, rq_wr_in;
   logic [PW-1:0]   rq_rd_ff, rq_rd_in;
   logic [CW-1:0]   rq_count_ff, rq_count_in;
   logic            rq_push, rq_pop, rq_full;

   assign rq_full   = (rq_count_ff == CW'(RSPQ_DEPTH));
   assign op_take   = op_valid && !rq_full;
   assign first_len = length_of_type(op_item.data[3:0]);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (op_take) begin
         if (op_item.is_done) begin
            phase_in = PH_READY;
         end else begin
            case (phase_ff)
               PH_COMPLETED: phase_in = PH_COMPLETED;
               PH_RECEIVING: begin
                  if (bytes_left_ff <= 2'd1) phase_in = PH_COMPLETED;
               end
               default: begin
                  phase_in = (first_len == 3'd1) ? PH_COMPLETED : PH_RECEIVING;
               end
            endcase
         end
      end
   end

   // Store, counters and result generation
   always_comb begin
      bytes_left_in  = bytes_left_ff;
      write_index_in = write_index_ff;
      store_in       = store_ff;
      emit           = 1'b0;
      emit_ovr       = 1'b0;
      if (op_take && !op_item.is_done) begin
         case (phase_ff)
            PH_COMPLETED: begin
               emit     = 1'b1;
               emit_ovr = 1'b1;
            end
            PH_RECEIVING: begin
               store_in[write_index_ff] = op_item.data;
               if (bytes_left_ff <= 2'd1) begin
                  bytes_left_in = 2'd0;
                  emit          = 1'b1;
               end else begin
                  bytes_left_in  = bytes_left_ff - 2'd1;
                  write_index_in = write_index_ff + 2'd1;
               end
            end
            default: begin
               store_in[0]   = op_item.data;
               bytes_left_in = 2'(first_len - 3'd1);
               if (first_len == 3'd1) begin
                  write_index_in = 2'd0;
                  emit           = 1'b1;
               end else begin
                  write_index_in = 2'd1;
               end
            end
         endcase
      end
   end

   // Result fields from the updated store
   always_comb begin
      rsp_new.command_type = store_in[0][3:0];
      rsp_new.direction    = store_in[0][7:4];
      rsp_new.arg_byte     = store_in[1];
      rsp_new.arg_word     = {store_in[3], store_in[2]};
      rsp_new.byte_count   = length_of_type(store_in[0][3:0]);
      rsp_new.overrun      = emit_ovr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_READY;
         bytes_left_ff  <= '0;
         write_index_ff <= '0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         write_index_ff <= write_index_in;
         store_ff       <= store_in;
      end
   end

   // Result queue
   assign rq_push  = emit;
   assign empty    = (rq_count_ff == '0);
   assign rq_pop   = pop && !empty;
   assign rsp_item = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = rq_wr_ff;
      rq_rd_in    = rq_rd_ff;
      rq_count_in = rq_count_ff;
      if (rq_push) begin
         rq_wr_in = (rq_wr_ff == PW'(RSPQ_DEPTH - 1)) ? '0 : rq_wr_ff + 1'b1;
      end
      if (rq_pop) begin
         rq_rd_in = (rq_rd_ff == PW'(RSPQ_DEPTH - 1)) ? '0 : rq_rd_ff + 1'b1;
      end
      if (rq_push && !rq_pop) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (!rq_push && rq_pop) begin
         rq_count_in = rq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= rsp_new;
      end
   end

endmodule
